// ===== hdl/tsolve_pkg.sv =====
// Shared types, constants and Q16.16 helper functions for the tridiagonal solver.
// No dependencies.
package tsolve_pkg;

    localparam int QW = 32;
    localparam int PW = 64;
    localparam int DVW = 48;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // Divider result handed to the sequencer
    typedef struct packed {
        logic                 done;
        logic                 zero_div;
        logic signed [QW-1:0] quo;
    } t_div_res;

    // Product >> 16 with floor rounding, saturated to 32 bits
    function automatic logic signed [QW-1:0] q_mul_fix(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p >>> 16;
        if (s > PW'(Q_MAX)) begin
            return Q_MAX;
        end else if (s < PW'(Q_MIN)) begin
            return Q_MIN;
        end
        return s[QW-1:0];
    endfunction

    // Exact difference, saturated to 32 bits
    function automatic logic signed [QW-1:0] q_sub(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [QW:0] d;
        d = {a[QW-1], a} - {b[QW-1], b};
        if (d[QW] != d[QW-1]) begin
            return d[QW] ? Q_MIN : Q_MAX;
        end
        return d[QW-1:0];
    endfunction

endpackage

// ===== hdl/tsolve_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tsolve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/tsolve_div.sv =====
// Iterative Q16.16 divider: restoring division, one quotient bit per cycle.
// Depends on tsolve_pkg.
module tsolve_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_num,
    input  logic signed [31:0]   i_den,
    output tsolve_pkg::t_div_res o_res
);
    import tsolve_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate          r_state;
    logic [5:0]       r_cnt;
    logic [DVW-1:0]   r_dvd;
    logic [QW-1:0]    r_rem;
    logic [QW-1:0]    r_dmag;
    logic             r_neg;
    logic             r_zero;
    logic             r_nneg;
    t_div_res         r_res;

    logic [QW:0]      rem_sh;
    logic [QW:0]      rem_diff;
    logic [QW-1:0]    nmag;
    logic [QW-1:0]    dmag;

    // Magnitudes and one restoring step
    always_comb begin
        nmag     = i_num[QW-1] ? QW'(-i_num) : QW'(i_num);
        dmag     = i_den[QW-1] ? QW'(-i_den) : QW'(i_den);
        rem_sh   = {r_rem, r_dvd[DVW-1]};
        rem_diff = rem_sh - {1'b0, r_dmag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= D_IDLE;
            r_res.done <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_res.done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dvd  <= {nmag, 16'b0};
                        r_rem  <= '0;
                        r_dmag <= dmag;
                        r_neg  <= i_num[QW-1] ^ i_den[QW-1];
                        r_nneg <= ~i_num[QW-1];
                        r_zero <= (i_den == '0);
                        r_cnt  <= 6'(DVW);
                        r_state <= (i_den == '0) ? D_FIN : D_RUN;
                    end
                end
                D_RUN: begin
                    // Shift in one dividend bit, keep remainder below divisor
                    if (!rem_diff[QW]) begin
                        r_rem <= rem_diff[QW-1:0];
                        r_dvd <= {r_dvd[DVW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[QW-1:0];
                        r_dvd <= {r_dvd[DVW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    // Apply sign and saturate
                    r_res.done     <= 1'b1;
                    r_res.zero_div <= r_zero;
                    if (r_zero) begin
                        r_res.quo <= r_nneg ? Q_MAX : Q_MIN;
                    end else if (!r_neg) begin
                        r_res.quo <= (r_dvd > DVW'(48'h7FFF_FFFF)) ? Q_MAX : r_dvd[QW-1:0];
                    end else begin
                        r_res.quo <= (r_dvd > DVW'(48'h8000_0000)) ? Q_MIN
                                   : QW'(-r_dvd[QW-1:0]);
                    end
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_res = r_res;
endmodule

// ===== hdl/tridiagonal_system_solver.sv =====
// Top level of the tridiagonal solver: row sequencer, shared multiplier, stores.
// Depends on tsolve_pkg, tsolve_ram and tsolve_div.
//
// Solves a tridiagonal system in signed Q16.16 by the Thomas algorithm. Send one
// row per input transfer (tlast marks the final row); after the final row the
// solution elements come out from the last row down to row zero, with their row
// index, the final element flagged by tlast, and tuser carrying the singular and
// dropped-row flags. Each row is paced by the two 48-step divisions of the shared
// bit-serial divider, each with a result handoff (a zero divisor skips the steps);
// row zero also skips the multiply and subtract stages. With the output open each
// solution element goes through store read, shared multiply, subtract and output
// load, the first skipping the multiply and subtract. Rows beyond MAX_ROWS are
// dropped and flagged. Input is not accepted while a row or the back substitution
// is in progress.
module tridiagonal_system_solver #(
    parameter int MAX_ROWS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] sub_coeff, [63:32] main_coeff, [95:64] super_coeff, [127:96] rhs_value
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,  // final_row
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] solution_value, [36:32] row_index, [39:37] zero
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,  // last_out
    // [0] singular, [1] overflow_rows
    output logic [1:0]   m_axis_tuser
);
    import tsolve_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int RW = (AW > 5) ? AW : 5;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_D, S_SUB_D, S_START_C, S_WAIT_C, S_START_D, S_WAIT_D,
        S_BS_RD, S_BS_DAT, S_BS_SUB, S_OUT
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_rows;
    logic                 r_sing;
    logic                 r_ovf;
    logic                 r_final;
    logic signed [QW-1:0] r_sub, r_main, r_super, r_rhs;
    logic signed [QW-1:0] r_prev_cp, r_prev_dp;
    logic signed [QW-1:0] r_den, r_num, r_x;
    logic signed [PW-1:0] r_prod;
    logic [AW-1:0]        r_k;
    logic                 r_first;
    logic                 r_oval;
    logic signed [QW-1:0] r_oval_x;
    logic [4:0]           r_orow;
    logic                 r_olast, r_osing, r_oovf;

    logic                 div_start;
    logic signed [QW-1:0] div_num;
    t_div_res             div_res;
    logic                 we_cp, we_dp;
    logic [QW-1:0]        cp_rd, dp_rd;
    logic                 in_xfer;
    logic signed [QW-1:0] in_sub;
    logic [RW-1:0]        k_ext;

    assign in_sub  = s_axis_tdata[31:0];
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign k_ext   = RW'(r_k);

    // Divider operand select and store writes
    assign div_start = (r_state == S_START_C) || (r_state == S_START_D);
    assign div_num   = (r_state == S_START_C) ? r_super : r_num;
    assign we_cp     = (r_state == S_WAIT_C) && div_res.done;
    assign we_dp     = (r_state == S_WAIT_D) && div_res.done;

    tsolve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_res   (div_res)
    );

    tsolve_ram #(.WIDTH(QW), .DEPTH(MAX_ROWS)) u_cp_ram (
        .i_clk   (i_clk),
        .i_we    (we_cp),
        .i_waddr (r_rows[AW-1:0]),
        .i_wdata (div_res.quo),
        .i_raddr (r_k),
        .o_rdata (cp_rd)
    );

    tsolve_ram #(.WIDTH(QW), .DEPTH(MAX_ROWS)) u_dp_ram (
        .i_clk   (i_clk),
        .i_we    (we_dp),
        .i_waddr (r_rows[AW-1:0]),
        .i_wdata (div_res.quo),
        .i_raddr (r_k),
        .o_rdata (dp_rd)
    );

    // Sequencer with registered output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= '0;
            r_sing  <= 1'b0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
            r_k     <= '0;
            r_first <= 1'b0;
        end else begin
            // Drop the output once transferred, unless a new element is loaded
            if (r_oval && m_axis_tready && r_state != S_OUT) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sub   <= in_sub;
                        r_main  <= s_axis_tdata[63:32];
                        r_super <= s_axis_tdata[95:64];
                        r_rhs   <= s_axis_tdata[127:96];
                        r_final <= s_axis_tlast;
                        r_prod  <= in_sub * r_prev_cp;
                        if (r_rows < CW'(MAX_ROWS)) begin
                            if (r_rows == '0) begin
                                r_den   <= s_axis_tdata[63:32];
                                r_num   <= s_axis_tdata[127:96];
                                r_state <= S_START_C;
                            end else begin
                                r_state <= S_MUL_D;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                            if (s_axis_tlast && r_rows != '0) begin
                                r_k     <= AW'(r_rows - CW'(1));
                                r_first <= 1'b1;
                                r_state <= S_BS_RD;
                            end
                        end
                    end
                end
                S_MUL_D: begin
                    r_den   <= q_sub(r_main, q_mul_fix(r_prod));
                    r_prod  <= r_sub * r_prev_dp;
                    r_state <= S_SUB_D;
                end
                S_SUB_D: begin
                    r_num   <= q_sub(r_rhs, q_mul_fix(r_prod));
                    r_state <= S_START_C;
                end
                S_START_C: r_state <= S_WAIT_C;
                S_WAIT_C: begin
                    if (div_res.done) begin
                        r_prev_cp <= div_res.quo;
                        if (div_res.zero_div) r_sing <= 1'b1;
                        r_state <= S_START_D;
                    end
                end
                S_START_D: r_state <= S_WAIT_D;
                S_WAIT_D: begin
                    if (div_res.done) begin
                        r_prev_dp <= div_res.quo;
                        if (div_res.zero_div) r_sing <= 1'b1;
                        r_rows <= r_rows + CW'(1);
                        if (r_final) begin
                            r_k     <= r_rows[AW-1:0];
                            r_first <= 1'b1;
                            r_state <= S_BS_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_BS_RD: r_state <= S_BS_DAT;
                S_BS_DAT: begin
                    if (r_first) begin
                        r_x     <= dp_rd;
                        r_state <= S_OUT;
                    end else begin
                        r_prod  <= $signed(cp_rd) * r_x;
                        r_state <= S_BS_SUB;
                    end
                end
                S_BS_SUB: begin
                    r_x     <= q_sub(dp_rd, q_mul_fix(r_prod));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_oval || m_axis_tready) begin
                        r_oval   <= 1'b1;
                        r_oval_x <= r_x;
                        r_orow   <= k_ext[4:0];
                        r_olast  <= (r_k == '0);
                        r_osing  <= r_sing;
                        r_oovf   <= r_ovf;
                        r_first  <= 1'b0;
                        if (r_k == '0) begin
                            r_rows  <= '0;
                            r_sing  <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k - AW'(1);
                            r_state <= S_BS_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {3'b000, r_orow, r_oval_x};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_oovf, r_osing};
endmodule
